// File: sv/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

  // Default sizes of the stores and of the per-tick event cap.
  localparam int unsigned SongDepthDef      = 1024;
  localparam int unsigned NoteTableDepthDef = 256;
  localparam int unsigned MaxEventsDef      = 16;

  // Request kinds carried in req_type.
  localparam logic [2:0] REQ_LOAD_SONG = 3'd0;
  localparam logic [2:0] REQ_LOAD_NOTE = 3'd1;
  localparam logic [2:0] REQ_START     = 3'd2;
  localparam logic [2:0] REQ_TICK      = 3'd3;
  localparam logic [2:0] REQ_STOP      = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NOTE_OFF    = 2'd0;
  localparam logic [1:0] CFG_NOTE_ON     = 2'd1;
  localparam logic [1:0] CFG_MODE_CHANGE = 2'd2;
  localparam logic [1:0] CFG_LOOP        = 2'd3;

  // Command code reset values.
  localparam logic [15:0] CODE_NOTE_OFF_RST    = 16'd0;
  localparam logic [15:0] CODE_NOTE_ON_RST     = 16'd1;
  localparam logic [15:0] CODE_MODE_CHANGE_RST = 16'd2;
  localparam logic [15:0] CODE_LOOP_RST        = 16'd3;

  // Sound chip register numbers and fixed data bytes.
  localparam logic [3:0] CHIP_NOISE = 4'd6;
  localparam logic [3:0] CHIP_MIXER = 4'd7;
  localparam logic [3:0] CHIP_VOL_A = 4'd8;
  localparam logic [3:0] CHIP_VOL_B = 4'd9;
  localparam logic [3:0] CHIP_VOL_C = 4'd10;

  localparam logic [7:0] NOISE_SETUP  = 8'h01;
  localparam logic [7:0] MIX_TONE_ALL = 8'h78;
  localparam logic [7:0] MIX_NOISE_A  = 8'h71;
  localparam logic [7:0] VOL_MASK     = 8'h0F;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  load_index;
    logic [15:0] song_word;
    logic [7:0]  period_fine;
    logic [7:0]  period_coarse;
  } req_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } res_t;

endpackage

// File: sv/tracker_song_sequencer.sv
`timescale 1ns / 1ps
// A start transaction gives its five chip writes and a stop gives three; loads give none.
// A tick compares the beat word and then reads each due event word by word, a note on
// taking the most steps. The single song memory read port sets the pace: every song
// word read waits on its registered read.
// One transaction at a time is taken; busy_o is high until the last write has been shown.
// Reset clears control, playback counters and command codes; the memories are not cleared.
module tracker_song_sequencer import tss_pkg::*; #(
  parameter int unsigned SONG_DEPTH          = SongDepthDef,
  parameter int unsigned NOTE_TABLE_DEPTH    = NoteTableDepthDef,
  parameter int unsigned MAX_EVENTS_PER_TICK = MaxEventsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam int unsigned SAW = $clog2(SONG_DEPTH);
  localparam int unsigned NAW = $clog2(NOTE_TABLE_DEPTH);
  localparam int unsigned EVW = $clog2(MAX_EVENTS_PER_TICK + 1);
  localparam int unsigned RW  = 10;
  localparam int unsigned UPW = 5;

  // Micro-operations. Each control word of the program names one of these, a constant
  // chip register and byte for fixed writes, and the address of the following step.
  typedef enum logic [4:0] {
    UOP_DISPATCH,
    UOP_FIN,
    UOP_INIT,
    UOP_EMIT,
    UOP_WR_SONG,
    UOP_WR_NOTE,
    UOP_TCHK,
    UOP_WAIT,
    UOP_TCMP,
    UOP_DECODE,
    UOP_OFF_CH,
    UOP_LATCH_CH,
    UOP_LATCH_NOTE,
    UOP_RED_NOTE,
    UOP_LATCH_VOL,
    UOP_EMIT_FINE,
    UOP_EMIT_COARSE,
    UOP_EMIT_VOL,
    UOP_MODE_FLAG,
    UOP_EMIT_MIX
  } uop_e;

  typedef struct packed {
    uop_e           op;
    logic [3:0]     addr;
    logic [7:0]     data;
    logic [UPW-1:0] nxt;
  } uword_t;

  // Program addresses.
  localparam logic [UPW-1:0] U_IDLE    = 5'd0;
  localparam logic [UPW-1:0] U_FIN     = 5'd1;
  localparam logic [UPW-1:0] U_START   = 5'd2;
  localparam logic [UPW-1:0] U_STOP    = 5'd8;
  localparam logic [UPW-1:0] U_WRS     = 5'd11;
  localparam logic [UPW-1:0] U_WRN     = 5'd12;
  localparam logic [UPW-1:0] U_TICK    = 5'd13;
  localparam logic [UPW-1:0] U_TWAIT   = 5'd14;
  localparam logic [UPW-1:0] U_DECODE  = 5'd17;
  localparam logic [UPW-1:0] U_OFF     = 5'd18;
  localparam logic [UPW-1:0] U_ON      = 5'd20;
  localparam logic [UPW-1:0] U_MODE    = 5'd29;

  // The control store. Steps that wait on the song memory read are plain WAIT words.
  function automatic uword_t urom(input logic [UPW-1:0] a);
    uword_t w;
    w = '{op: UOP_DISPATCH, addr: 4'd0, data: 8'd0, nxt: U_IDLE};
    case (a)
      5'd0:  w = '{op: UOP_DISPATCH,    addr: 4'd0,       data: 8'd0,         nxt: U_IDLE};
      5'd1:  w = '{op: UOP_FIN,         addr: 4'd0,       data: 8'd0,         nxt: U_IDLE};
      // Start: rewind, set up noise and mixer, silence the voices.
      5'd2:  w = '{op: UOP_INIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd3};
      5'd3:  w = '{op: UOP_EMIT,        addr: CHIP_NOISE, data: NOISE_SETUP,  nxt: 5'd4};
      5'd4:  w = '{op: UOP_EMIT,        addr: CHIP_MIXER, data: MIX_TONE_ALL, nxt: 5'd5};
      5'd5:  w = '{op: UOP_EMIT,        addr: CHIP_VOL_A, data: 8'd0,         nxt: 5'd6};
      5'd6:  w = '{op: UOP_EMIT,        addr: CHIP_VOL_B, data: 8'd0,         nxt: 5'd7};
      5'd7:  w = '{op: UOP_EMIT,        addr: CHIP_VOL_C, data: 8'd0,         nxt: U_FIN};
      // Stop.
      5'd8:  w = '{op: UOP_EMIT,        addr: CHIP_VOL_A, data: 8'd0,         nxt: 5'd9};
      5'd9:  w = '{op: UOP_EMIT,        addr: CHIP_VOL_B, data: 8'd0,         nxt: 5'd10};
      5'd10: w = '{op: UOP_EMIT,        addr: CHIP_VOL_C, data: 8'd0,         nxt: U_FIN};
      // Loads.
      5'd11: w = '{op: UOP_WR_SONG,     addr: 4'd0,       data: 8'd0,         nxt: U_FIN};
      5'd12: w = '{op: UOP_WR_NOTE,     addr: 4'd0,       data: 8'd0,         nxt: U_FIN};
      // Tick: event loop.
      5'd13: w = '{op: UOP_TCHK,        addr: 4'd0,       data: 8'd0,         nxt: U_TWAIT};
      5'd14: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd15};
      5'd15: w = '{op: UOP_TCMP,        addr: 4'd0,       data: 8'd0,         nxt: 5'd16};
      5'd16: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: U_DECODE};
      5'd17: w = '{op: UOP_DECODE,      addr: 4'd0,       data: 8'd0,         nxt: U_FIN};
      // Note off.
      5'd18: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd19};
      5'd19: w = '{op: UOP_OFF_CH,      addr: 4'd0,       data: 8'd0,         nxt: U_TWAIT};
      // Note on.
      5'd20: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd21};
      5'd21: w = '{op: UOP_LATCH_CH,    addr: 4'd0,       data: 8'd0,         nxt: 5'd22};
      5'd22: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd23};
      5'd23: w = '{op: UOP_LATCH_NOTE,  addr: 4'd0,       data: 8'd0,         nxt: 5'd24};
      5'd24: w = '{op: UOP_RED_NOTE,    addr: 4'd0,       data: 8'd0,         nxt: 5'd25};
      5'd25: w = '{op: UOP_LATCH_VOL,   addr: 4'd0,       data: 8'd0,         nxt: 5'd26};
      5'd26: w = '{op: UOP_EMIT_FINE,   addr: 4'd0,       data: 8'd0,         nxt: 5'd27};
      5'd27: w = '{op: UOP_EMIT_COARSE, addr: 4'd0,       data: 8'd0,         nxt: 5'd28};
      5'd28: w = '{op: UOP_EMIT_VOL,    addr: 4'd0,       data: 8'd0,         nxt: U_TWAIT};
      // Mode change.
      5'd29: w = '{op: UOP_WAIT,        addr: 4'd0,       data: 8'd0,         nxt: 5'd30};
      5'd30: w = '{op: UOP_MODE_FLAG,   addr: CHIP_VOL_A, data: 8'd0,         nxt: 5'd31};
      5'd31: w = '{op: UOP_EMIT_MIX,    addr: CHIP_MIXER, data: 8'd0,         nxt: U_TWAIT};
      default: w = '{op: UOP_FIN,       addr: 4'd0,       data: 8'd0,         nxt: U_IDLE};
    endcase
    return w;
  endfunction

  // Memories: song words and note periods (coarse byte high, fine byte low).
  logic [15:0] song_mem [SONG_DEPTH];
  logic [15:0] note_mem [NOTE_TABLE_DEPTH];

  logic [UPW-1:0] upc_q, upc_d;
  logic [SAW-1:0] ptr_q, ptr_d;
  logic [15:0]    beat_q, beat_d;
  logic           started_q, started_d;
  logic [EVW-1:0] events_q, events_d;
  logic [RW-1:0]  red_q, red_d;
  logic [15:0]    wdata_q;
  logic [7:0]     ch_q, ch_d;
  logic [3:0]     vol_q, vol_d;
  logic           flag_q, flag_d;
  logic [15:0]    rdata_q;
  logic [15:0]    nrd_q;
  logic [15:0]    code_q [4];
  res_t           pend_q, pend_d;
  logic           pend_v_q, pend_v_d;
  res_t           res_q, res_d;
  logic           res_v_q, res_v_d;

  uword_t         uw;
  logic           song_we, note_we;
  logic           emit_v;
  logic [3:0]     emit_addr;
  logic [7:0]     emit_data;
  logic [SAW-1:0] ptr_inc;
  logic           ch_ok;
  logic [7:0]     rd_ch;

  assign uw      = urom(upc_q);
  assign ptr_inc = (ptr_q == SAW'(SONG_DEPTH - 1)) ? '0 : ptr_q + SAW'(1);
  assign ch_ok   = (ch_q < 8'd3);
  assign rd_ch   = rdata_q[7:0];

  always_comb begin
    upc_d     = uw.nxt;
    ptr_d     = ptr_q;
    beat_d    = beat_q;
    started_d = started_q;
    events_d  = events_q;
    red_d     = red_q;
    ch_d      = ch_q;
    vol_d     = vol_q;
    flag_d    = flag_q;
    song_we   = 1'b0;
    note_we   = 1'b0;
    emit_v    = 1'b0;
    emit_addr = uw.addr;
    emit_data = uw.data;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    res_d     = res_q;
    res_v_d   = 1'b0;

    case (uw.op)
      UOP_DISPATCH: begin
        // Entry decode is handled in the clocked block on an accepted transaction.
        upc_d = U_IDLE;
      end
      UOP_FIN: begin
        if (pend_v_q) begin
          res_v_d    = 1'b1;
          res_d      = pend_q;
          res_d.last = 1'b1;
        end
        pend_v_d = 1'b0;
      end
      UOP_INIT: begin
        started_d = 1'b1;
        ptr_d     = '0;
        beat_d    = '0;
      end
      UOP_EMIT: begin
        emit_v = 1'b1;
      end
      UOP_WR_SONG: begin
        // Bring the load index into range one subtraction per cycle.
        if (32'(red_q) >= 32'(SONG_DEPTH)) begin
          red_d = red_q - RW'(SONG_DEPTH);
          upc_d = upc_q;
        end else begin
          song_we = 1'b1;
        end
      end
      UOP_WR_NOTE: begin
        if (32'(red_q) >= 32'(NOTE_TABLE_DEPTH)) begin
          red_d = red_q - RW'(NOTE_TABLE_DEPTH);
          upc_d = upc_q;
        end else begin
          note_we = 1'b1;
        end
      end
      UOP_TCHK: begin
        events_d = '0;
        if (!started_q) begin
          upc_d = U_FIN;
        end
      end
      UOP_WAIT: begin
      end
      UOP_TCMP: begin
        if (rdata_q != beat_q) begin
          beat_d = beat_q + 16'd1;
          upc_d  = U_FIN;
        end else if (32'(events_q) >= 32'(MAX_EVENTS_PER_TICK)) begin
          upc_d = U_FIN;
        end else begin
          events_d = events_q + EVW'(1);
          ptr_d    = ptr_inc;
        end
      end
      UOP_DECODE: begin
        // The first matching code wins when codes coincide.
        if (rdata_q == code_q[CFG_NOTE_OFF]) begin
          ptr_d = ptr_inc;
          upc_d = U_OFF;
        end else if (rdata_q == code_q[CFG_NOTE_ON]) begin
          ptr_d = ptr_inc;
          upc_d = U_ON;
        end else if (rdata_q == code_q[CFG_MODE_CHANGE]) begin
          ptr_d = ptr_inc;
          upc_d = U_MODE;
        end else if (rdata_q == code_q[CFG_LOOP]) begin
          ptr_d  = '0;
          beat_d = '0;
          upc_d  = U_TWAIT;
        end else begin
          upc_d = U_FIN;
        end
      end
      UOP_OFF_CH: begin
        emit_v    = (rd_ch < 8'd3);
        emit_addr = {2'b10, rd_ch[1:0]};
        emit_data = 8'd0;
        ptr_d     = ptr_inc;
      end
      UOP_LATCH_CH: begin
        ch_d  = rd_ch;
        ptr_d = ptr_inc;
      end
      UOP_LATCH_NOTE: begin
        red_d = RW'(rd_ch);
        ptr_d = ptr_inc;
      end
      UOP_RED_NOTE: begin
        if (32'(red_q) >= 32'(NOTE_TABLE_DEPTH)) begin
          red_d = red_q - RW'(NOTE_TABLE_DEPTH);
          upc_d = upc_q;
        end
      end
      UOP_LATCH_VOL: begin
        vol_d = rdata_q[3:0] & VOL_MASK[3:0];
        ptr_d = ptr_inc;
      end
      UOP_EMIT_FINE: begin
        emit_v    = ch_ok;
        emit_addr = {1'b0, ch_q[1:0], 1'b0};
        emit_data = nrd_q[7:0];
      end
      UOP_EMIT_COARSE: begin
        emit_v    = ch_ok;
        emit_addr = {1'b0, ch_q[1:0], 1'b1};
        emit_data = nrd_q[15:8];
      end
      UOP_EMIT_VOL: begin
        emit_v    = ch_ok;
        emit_addr = {2'b10, ch_q[1:0]};
        emit_data = {4'd0, vol_q};
      end
      UOP_MODE_FLAG: begin
        flag_d = (rdata_q != 16'd0);
        emit_v = 1'b1;
        ptr_d  = ptr_inc;
      end
      UOP_EMIT_MIX: begin
        emit_v    = 1'b1;
        emit_data = flag_q ? MIX_TONE_ALL : MIX_NOISE_A;
      end
      default: begin
        upc_d = U_FIN;
      end
    endcase

    // One write is held back so that the final write of a transaction can carry last.
    if (emit_v) begin
      if (pend_v_q) begin
        res_v_d = 1'b1;
        res_d   = pend_q;
      end
      pend_d   = '{reg_addr: emit_addr, reg_data: emit_data, last: 1'b0};
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q     <= U_IDLE;
      ptr_q     <= '0;
      beat_q    <= '0;
      started_q <= 1'b0;
      events_q  <= '0;
      pend_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
      code_q[CFG_NOTE_OFF]    <= CODE_NOTE_OFF_RST;
      code_q[CFG_NOTE_ON]     <= CODE_NOTE_ON_RST;
      code_q[CFG_MODE_CHANGE] <= CODE_MODE_CHANGE_RST;
      code_q[CFG_LOOP]        <= CODE_LOOP_RST;
    end else begin
      ptr_q     <= ptr_d;
      beat_q    <= beat_d;
      started_q <= started_d;
      events_q  <= events_d;
      pend_v_q  <= pend_v_d;
      res_v_q   <= res_v_d;
      if (cfg_we_i) begin
        code_q[cfg_index_i] <= cfg_data_i;
      end
      if (upc_q == U_IDLE) begin
        if (start_i) begin
          case (req_i.req_type)
            REQ_LOAD_SONG: upc_q <= U_WRS;
            REQ_LOAD_NOTE: upc_q <= U_WRN;
            REQ_START:     upc_q <= U_START;
            REQ_TICK:      upc_q <= U_TICK;
            REQ_STOP:      upc_q <= U_STOP;
            default:       upc_q <= U_FIN;
          endcase
        end
      end else begin
        upc_q <= upc_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    vol_q  <= vol_d;
    flag_q <= flag_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    if (upc_q == U_IDLE && start_i) begin
      red_q   <= req_i.load_index;
      wdata_q <= (req_i.req_type == REQ_LOAD_NOTE) ?
                 {req_i.period_coarse, req_i.period_fine} : req_i.song_word;
    end else begin
      red_q <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (song_we) begin
      song_mem[SAW'(red_q)] <= wdata_q;
    end
    rdata_q <= song_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (note_we) begin
      note_mem[NAW'(red_q)] <= wdata_q;
    end
    nrd_q <= note_mem[NAW'(red_q)];
  end

  assign busy_o      = (upc_q != U_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// File: dv/tss_chip_write_checker.sv
`timescale 1ns / 1ps

module tss_chip_write_checker import tss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        res_valid_i,
  input  res_t        res_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int unsigned SongAw = $clog2(SongDepthDef);
  localparam int unsigned NoteAw = $clog2(NoteTableDepthDef);

  logic [15:0]       song_mem   [SongDepthDef];
  logic [15:0]       period_tab [NoteTableDepthDef];
  logic [SongAw-1:0] ev_ptr;
  logic [15:0]       beat;
  logic              playing;
  logic [15:0]       off_code;
  logic [15:0]       on_code;
  logic [15:0]       mode_code;
  logic [15:0]       loop_code;
  res_t              chip_writes_q[$];
  int                mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t tss_chip_write_checker: %s", $time, msg);
    end
  endtask

  function automatic logic [15:0] word_at(input int unsigned ofs);
    logic [SongAw-1:0] addr;
    addr = ev_ptr + SongAw'(ofs);
    return song_mem[addr];
  endfunction

  task automatic push_write(input logic [3:0] addr, input logic [7:0] data);
    res_t w;
    w.reg_addr = addr;
    w.reg_data = data;
    w.last     = 1'b0;
    chip_writes_q.push_back(w);
  endtask

  task automatic mute_voices();
    push_write(CHIP_VOL_A, 8'h00);
    push_write(CHIP_VOL_B, 8'h00);
    push_write(CHIP_VOL_C, 8'h00);
  endtask

  // Runs every event due on the current beat. A capped tick and an unknown
  // command both leave the beat where it is.
  task automatic play_tick();
    int unsigned       runs;
    logic [15:0]       cmd;
    logic [15:0]       arg;
    logic [7:0]        ch;
    logic [NoteAw-1:0] note;
    logic [15:0]       period;
    if (!playing) return;
    runs = 0;
    while (word_at(0) == beat) begin
      if (runs >= MaxEventsDef) return;
      runs++;
      ev_ptr = ev_ptr + SongAw'(1);
      cmd = word_at(0);
      if (cmd == off_code) begin
        arg = word_at(1);
        ch  = arg[7:0];
        if (ch < 8'd3) push_write(CHIP_VOL_A + 4'(ch), 8'h00);
        ev_ptr = ev_ptr + SongAw'(2);
      end else if (cmd == on_code) begin
        arg  = word_at(1);
        ch   = arg[7:0];
        arg  = word_at(2);
        note = arg[NoteAw-1:0];
        arg  = word_at(3);
        if (ch < 8'd3) begin
          period = period_tab[note];
          push_write(4'(2 * ch), period[7:0]);
          push_write(4'(2 * ch + 1), period[15:8]);
          push_write(CHIP_VOL_A + 4'(ch), arg[7:0] & VOL_MASK);
        end
        ev_ptr = ev_ptr + SongAw'(4);
      end else if (cmd == mode_code) begin
        push_write(CHIP_VOL_A, 8'h00);
        push_write(CHIP_MIXER, (word_at(1) != 16'h0000) ? MIX_TONE_ALL : MIX_NOISE_A);
        ev_ptr = ev_ptr + SongAw'(2);
      end else if (cmd == loop_code) begin
        ev_ptr = '0;
        beat   = '0;
      end else begin
        return;
      end
    end
    beat = beat + 16'd1;
  endtask

  task automatic apply_request(input req_t r);
    int unsigned queued;
    res_t        tail;
    queued = chip_writes_q.size();
    case (r.req_type)
      REQ_LOAD_SONG: song_mem[r.load_index[SongAw-1:0]] = r.song_word;
      REQ_LOAD_NOTE: period_tab[r.load_index[NoteAw-1:0]] = {r.period_coarse, r.period_fine};
      REQ_START: begin
        playing = 1'b1;
        ev_ptr  = '0;
        beat    = '0;
        push_write(CHIP_NOISE, NOISE_SETUP);
        push_write(CHIP_MIXER, MIX_TONE_ALL);
        mute_voices();
      end
      REQ_TICK: play_tick();
      REQ_STOP: mute_voices();
      default: ;
    endcase
    if (chip_writes_q.size() > queued) begin
      tail = chip_writes_q.pop_back();
      tail.last = 1'b1;
      chip_writes_q.push_back(tail);
    end
  endtask

  task automatic check_write(input res_t got);
    res_t want;
    if (chip_writes_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected chip write addr %0d data 0x%02h last %0b",
                              got.reg_addr, got.reg_data, got.last));
      return;
    end
    want = chip_writes_q.pop_front();
    if (got.reg_addr !== want.reg_addr)
      flag_mismatch($sformatf("reg_addr %0d, expected %0d", got.reg_addr, want.reg_addr));
    if (got.reg_data !== want.reg_data)
      flag_mismatch($sformatf("reg_data 0x%02h, expected 0x%02h (addr %0d)",
                              got.reg_data, want.reg_data, want.reg_addr));
    if (got.last !== want.last)
      flag_mismatch($sformatf("last %0b, expected %0b (addr %0d)",
                              got.last, want.last, want.reg_addr));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_writes_q.delete();
      ev_ptr    = '0;
      beat      = '0;
      playing   = 1'b0;
      off_code  = CODE_NOTE_OFF_RST;
      on_code   = CODE_NOTE_ON_RST;
      mode_code = CODE_MODE_CHANGE_RST;
      loop_code = CODE_LOOP_RST;
    end else begin
      if (res_valid_i) check_write(res_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NOTE_OFF:    off_code  = cfg_data_i;
          CFG_NOTE_ON:     on_code   = cfg_data_i;
          CFG_MODE_CHANGE: mode_code = cfg_data_i;
          CFG_LOOP:        loop_code = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) apply_request(req_i);
    end
    pending_o <= chip_writes_q.size();
  end

endmodule

// File: dv/tracker_song_sequencer_test.sv
`timescale 1ns / 1ps

module tracker_song_sequencer_test;
  import tss_pkg::*;

  // Generous ceiling on the whole run; the slowest legal run is far shorter.
  localparam int unsigned RunLimitNs = 12_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  req_t        req       = '0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_NOTE_OFF;
  logic [15:0] cfg_data  = '0;
  logic        res_valid;
  res_t        res;
  int          mismatches;
  int          pending;

  // Copy of the command codes currently programmed, used to compose songs.
  logic [15:0] off_code  = CODE_NOTE_OFF_RST;
  logic [15:0] on_code   = CODE_NOTE_ON_RST;
  logic [15:0] mode_code = CODE_MODE_CHANGE_RST;
  logic [15:0] loop_code = CODE_LOOP_RST;

  // Song under construction; word i is loaded at song address i.
  logic [15:0] tune_q[$];

  int unsigned sent        = 0;
  int unsigned pause_odds  = 0;
  int unsigned quiet_after = '1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tracker_song_sequencer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The checker sees exactly what the block sees, predicts every chip write
  // and reports how many writes are still owed.
  tss_chip_write_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Occasionally drop start for a random burst so that gaps land on every
  // phase of the block's work. Idling stops for the closing stretch.
  task automatic maybe_pause();
    if (pause_odds != 0 && sent < quiet_after && $urandom_range(1, pause_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Presents one transaction and returns at the edge that accepts it. Start
  // is left high so that back-to-back transactions need a single assignment.
  task automatic issue(input req_t r);
    maybe_pause();
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Every field is randomized, including the ones the request kind ignores,
  // so that all input bits toggle.
  function automatic req_t random_req(input logic [2:0] kind);
    req_t r;
    r.req_type      = kind;
    r.load_index    = 10'($urandom);
    r.song_word     = 16'($urandom);
    r.period_fine   = 8'($urandom);
    r.period_coarse = 8'($urandom);
    return r;
  endfunction

  // A request type outside the defined set; the block must ignore it.
  function automatic req_t stray_req();
    req_t r;
    r = random_req(REQ_STOP);
    while (r.req_type <= REQ_STOP) r.req_type = 3'($urandom);
    return r;
  endfunction

  task automatic load_song_word(input logic [9:0] addr, input logic [15:0] w);
    req_t r;
    r = random_req(REQ_LOAD_SONG);
    r.load_index = addr;
    r.song_word  = w;
    issue(r);
  endtask

  task automatic load_tune();
    foreach (tune_q[i]) load_song_word(10'(i), tune_q[i]);
  endtask

  // Waits until the block is idle and owes nothing, then lets the longest
  // load latency pass, since a load leaves no write to wait for.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_codes(input logic [15:0] c_off, input logic [15:0] c_on,
                           input logic [15:0] c_mode, input logic [15:0] c_loop);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NOTE_OFF;
    cfg_data  <= c_off;
    @(posedge clk);
    cfg_index <= CFG_NOTE_ON;
    cfg_data  <= c_on;
    @(posedge clk);
    cfg_index <= CFG_MODE_CHANGE;
    cfg_data  <= c_mode;
    @(posedge clk);
    cfg_index <= CFG_LOOP;
    cfg_data  <= c_loop;
    @(posedge clk);
    cfg_we    <= 1'b0;
    off_code  = c_off;
    on_code   = c_on;
    mode_code = c_mode;
    loop_code = c_loop;
  endtask

  // A command word that matches none of the programmed codes.
  function automatic logic [15:0] stray_code();
    logic [15:0] w;
    do w = 16'($urandom);
    while (w == off_code || w == on_code || w == mode_code || w == loop_code);
    return w;
  endfunction

  // Mostly valid voices, plus channel 3, words whose low byte is a valid
  // voice under a busy high byte, and fully random words.
  function automatic logic [15:0] pick_channel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 5) return 16'(pick % 4);
    else if (pick < 7) return {8'($urandom), 8'($urandom_range(0, 2))};
    else return 16'($urandom);
  endfunction

  task automatic add_off(input logic [15:0] t, input logic [15:0] ch);
    tune_q.push_back(t);
    tune_q.push_back(off_code);
    tune_q.push_back(ch);
  endtask

  task automatic add_on(input logic [15:0] t, input logic [15:0] ch,
                        input logic [15:0] note, input logic [15:0] vol);
    tune_q.push_back(t);
    tune_q.push_back(on_code);
    tune_q.push_back(ch);
    tune_q.push_back(note);
    tune_q.push_back(vol);
  endtask

  task automatic add_mode(input logic [15:0] t, input logic [15:0] tone_flag);
    tune_q.push_back(t);
    tune_q.push_back(mode_code);
    tune_q.push_back(tone_flag);
  endtask

  task automatic add_loop(input logic [15:0] t);
    tune_q.push_back(t);
    tune_q.push_back(loop_code);
  endtask

  // Builds a well-formed song with random content. A burst song puts every
  // event but a closing loop on beat zero so that the per-tick event cap is reached.
  task automatic build_tune(input int unsigned n_events, input bit burst);
    logic [15:0] t;
    int unsigned pick;
    t = '0;
    tune_q.delete();
    for (int unsigned e = 0; e < n_events; e++) begin
      if (!burst && $urandom_range(0, 2) == 0) t = t + 16'($urandom_range(1, 2));
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        add_off(t, pick_channel());
      end else if (pick < 13) begin
        add_on(t, pick_channel(), 16'($urandom), 16'($urandom));
      end else if (pick < 17) begin
        add_mode(t, ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom));
      end else if (pick < 18) begin
        add_loop(t);
      end else begin
        tune_q.push_back(t);
        tune_q.push_back(stray_code());
      end
    end
    if ($urandom_range(0, 1) == 0) add_loop(t + 16'd1);
  endtask

  initial begin
    req_t        r;
    logic [15:0] w;
    int unsigned base;
    int unsigned phase;
    int unsigned pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both stores are filled completely first, so no later transaction can
    // read an entry that was never written. The song memory is filled with
    // back-to-back note-on events that all fall on beat zero; playing it
    // walks the event pointer past the top of memory and wraps it.
    pause_odds = 8;
    for (int a = 0; a < SongDepthDef; a++) begin
      case (a % 5)
        0:       w = '0;
        1:       w = on_code;
        2:       w = 16'($urandom_range(0, 3));
        default: w = 16'($urandom);
      endcase
      load_song_word(10'(a), w);
    end
    for (int n = 0; n < NoteTableDepthDef; n++) begin
      r = random_req(REQ_LOAD_NOTE);
      r.load_index = 10'(n);
      issue(r);
    end

    // Directed: a tick before start does nothing, stop mutes regardless,
    // an undefined request is ignored. Then the ticks hit the event cap until
    // the fill pattern carries the pointer around the memory.
    issue(random_req(REQ_TICK));
    issue(random_req(REQ_STOP));
    issue(stray_req());
    issue(random_req(REQ_START));
    repeat (14) issue(random_req(REQ_TICK));
    issue(random_req(REQ_STOP));

    // Directed song: each voice, an out-of-range channel, a channel word
    // with a high byte, note and volume words with high bits set, both mixer
    // modes, then an unknown command that stalls the beat until it is
    // overwritten with a loop.
    tune_q.delete();
    add_off(16'd0, 16'd0);
    add_off(16'd0, 16'h0102);
    add_off(16'd0, 16'd3);
    add_on(16'd0, 16'd1, 16'hFFFF, 16'hABCD);
    add_on(16'd0, 16'h00FF, 16'd5, 16'd9);
    add_on(16'd0, 16'd0, 16'h1200, 16'h00FF);
    add_mode(16'd1, 16'h0000);
    add_mode(16'd1, 16'h8000);
    add_on(16'd2, 16'd2, 16'd7, 16'd15);
    tune_q.push_back(16'd3);
    tune_q.push_back(stray_code());
    load_tune();
    issue(random_req(REQ_START));
    repeat (5) issue(random_req(REQ_TICK));
    load_song_word(10'(tune_q.size() - 1), loop_code);
    repeat (2) issue(random_req(REQ_TICK));

    // Random phases: every second phase programs a code setting; each loads a fresh song, starts it
    // and plays it with stops, restarts, stray requests and loads mixed in.
    // Settings rotate through the extremes, coinciding codes, random codes
    // and the reset values.
    base        = sent;
    quiet_after = base + 250;
    phase       = 0;
    while (sent - base < 320) begin
      if (phase % 2 == 0) begin
        case ((phase / 2) % 4)
          0: set_codes(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
          1: begin
            w = 16'($urandom);
            set_codes(w, w, w, w);
          end
          2: set_codes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: set_codes(CODE_NOTE_OFF_RST, CODE_NOTE_ON_RST,
                             CODE_MODE_CHANGE_RST, CODE_LOOP_RST);
        endcase
      end
      pick       = $urandom_range(0, 3);
      pause_odds = (pick == 0) ? 0 : (1 << pick);
      if ($urandom_range(0, 4) == 0) build_tune($urandom_range(17, 24), 1'b1);
      else build_tune($urandom_range(1, 12), 1'b0);
      load_tune();
      issue(random_req(REQ_START));
      repeat ($urandom_range(3, 20)) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       issue(random_req(REQ_STOP));
          1:       issue(stray_req());
          2:       issue(random_req(REQ_LOAD_SONG));
          3:       issue(random_req(REQ_LOAD_NOTE));
          4:       issue(random_req(REQ_START));
          default: issue(random_req(REQ_TICK));
        endcase
      end
      phase++;
    end

    // Let every owed chip write arrive, then watch a while longer for
    // anything extra before giving the verdict.
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tracker_song_sequencer_test: PASS");
    end else begin
      $display("tracker_song_sequencer_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("tracker_song_sequencer_test: FAIL");
    $finish;
  end

endmodule
